/* hdl/mmf_pkg.sv */
// shared types, constants and helper functions for the 3x3 median / weighted-mean rgb filter
// no dependencies; imported by every module of the filter
package mmf_pkg;

	localparam int PIXEL_BITS = 8;
	localparam int IN_BITS    = 8;
	localparam int OUT_BITS   = 8;
	localparam int WIN        = 9;
	localparam int ROW_SLOTS  = 3;

	// eight non-centre samples, then plus twice the median
	localparam int PART_BITS  = PIXEL_BITS + 3;
	localparam int SUM_BITS   = PIXEL_BITS + 4;

	// divide by ten as multiply by a rounded-up reciprocal, exact for SUM_BITS inputs
	localparam int DIV_SHIFT  = SUM_BITS + 4;
	localparam int RECIP_BITS = SUM_BITS + 1;
	localparam int PROD_BITS  = SUM_BITS + RECIP_BITS;
	localparam logic [RECIP_BITS-1:0] DIV_RECIP =
		RECIP_BITS'(((64'd1 << DIV_SHIFT) + 64'd9) / 64'd10);

	localparam int POS_BITS  = 16;
	localparam int FILL_BITS = 4;
	localparam logic [POS_BITS-1:0]  ROW_POS_RESET = 16'd1024;
	localparam logic [FILL_BITS-1:0] FULL_LOAD     = 4'd9;
	localparam logic [FILL_BITS-1:0] COL_LOAD      = 4'd3;
	localparam logic [FILL_BITS-1:0] FIRST_COL_SLOT = 4'd2;

	// register map
	localparam int ADDR_BITS = 3;
	localparam int DATA_BITS = 32;
	localparam logic REG_ROW_POSITIONS = 1'b0;

	typedef logic [PIXEL_BITS-1:0] sample_t;
	typedef logic [OUT_BITS-1:0]   out_sample_t;

	typedef struct packed {
		logic [IN_BITS-1:0] red_in;
		logic [IN_BITS-1:0] green_in;
		logic [IN_BITS-1:0] blue_in;
	} pixel_in_t;

	typedef struct packed {
		logic [OUT_BITS-1:0] red_out;
		logic [OUT_BITS-1:0] green_out;
		logic [OUT_BITS-1:0] blue_out;
	} pixel_out_t;

	typedef struct packed {
		sample_t r;
		sample_t g;
		sample_t b;
	} rgb_t;

	typedef struct packed {
		sample_t hi;
		sample_t md;
		sample_t lo;
	} trio_t;

	// per-stage load enables of the datapath
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
		logic so;
	} stage_en_t;

	function automatic trio_t sort3(sample_t a, sample_t b, sample_t c);
		sample_t lo1;
		sample_t hi1;
		trio_t   r;
		lo1  = (a < b) ? a : b;
		hi1  = (a < b) ? b : a;
		r.lo = (c < lo1) ? c : lo1;
		r.hi = (c > hi1) ? c : hi1;
		r.md = (c < lo1) ? lo1 : ((c > hi1) ? hi1 : c);
		return r;
	endfunction

endpackage

/* hdl/mmf_cell.sv */
// one window slot holding an rgb sample; loads the incoming pixel or takes its right neighbour
// depends on mmf_pkg
module mmf_cell (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         load,
	input  logic         shift,
	input  mmf_pkg::rgb_t pix,
	input  mmf_pkg::rgb_t nbr,
	output mmf_pkg::rgb_t cur
);
	import mmf_pkg::*;

	rgb_t win_q;

	// value including a write landing this cycle
	assign cur = load ? pix : win_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
		end else if (shift) begin
			win_q <= nbr;
		end else if (load) begin
			win_q <= pix;
		end
	end

endmodule

/* hdl/mmf_chan.sv */
// one colour channel of the filter: window snapshot, row sorts, median, weighted sum, divide by ten
// depends on mmf_pkg
module mmf_chan (
	input  logic                  clk,
	input  mmf_pkg::stage_en_t    en,
	input  mmf_pkg::sample_t [8:0] win,
	output mmf_pkg::out_sample_t  res
);
	import mmf_pkg::*;

	sample_t [WIN-1:0]       w_s1;
	trio_t   [ROW_SLOTS-1:0] row_s2;
	logic [PART_BITS-1:0]    sum_s2;
	logic [PART_BITS-1:0]    sum_s3;
	sample_t                 lo_s3;
	sample_t                 md_s3;
	sample_t                 hi_s3;
	logic [SUM_BITS-1:0]     tot_s4;
	logic [PROD_BITS-1:0]    prod;
	out_sample_t             res_q;

	logic [PART_BITS-1:0] ring_sum;
	sample_t              med;

	always_comb begin
		ring_sum = '0;
		for (int i = 0; i < WIN; i++) begin
			if (i != 4) begin
				ring_sum = ring_sum + PART_BITS'(w_s1[i]);
			end
		end
	end

	assign med  = sort3(lo_s3, md_s3, hi_s3).md;
	assign prod = PROD_BITS'(tot_s4) * PROD_BITS'(DIV_RECIP);

	always_ff @(posedge clk) begin
		if (en.s1) begin
			w_s1 <= win;
		end
		if (en.s2) begin
			for (int r = 0; r < ROW_SLOTS; r++) begin
				row_s2[r] <= sort3(w_s1[3*r], w_s1[3*r+1], w_s1[3*r+2]);
			end
			sum_s2 <= ring_sum;
		end
		// median of nine from the sorted rows
		if (en.s3) begin
			lo_s3  <= sort3(row_s2[0].lo, row_s2[1].lo, row_s2[2].lo).hi;
			md_s3  <= sort3(row_s2[0].md, row_s2[1].md, row_s2[2].md).md;
			hi_s3  <= sort3(row_s2[0].hi, row_s2[1].hi, row_s2[2].hi).lo;
			sum_s3 <= sum_s2;
		end
		if (en.s4) begin
			tot_s4 <= SUM_BITS'(sum_s3) + (SUM_BITS'(med) << 1);
		end
		if (en.so) begin
			res_q <= out_sample_t'(prod >> DIV_SHIFT);
		end
	end

	assign res = res_q;

endmodule

/* hdl/median_mean_3x3_rgb_filter_unit.sv */
// top level of the 3x3 median / weighted-mean rgb filter: window cells, fill control, apb register
// depends on mmf_pkg, mmf_cell, mmf_chan
//
// channel   direction  handshake             payload
// pix       in         pix_valid/pix_ready   pixel_in_t (red_in, green_in, blue_in)
// res       out        res_valid/res_ready   pixel_out_t (red_out, green_out, blue_out)
// apb       in         psel/penable/pready   row_positions at byte address 0
//
// one pixel per cycle enters the row of nine window cells while pix_ready is high; a pixel that completes a window
// starts a five-register datapath per channel (snapshot, row sort, median, weighted sum,
// divide by ten), and res_valid rises once its result reaches the divide-by-ten register.
// reset clears the window, position and fill counters and sets row_positions to 1024.
// a held result stalls the datapath stage by stage; pixels that do not complete a window
// are still taken while the output waits.
module median_mean_3x3_rgb_filter_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pix_valid,
	output logic                              pix_ready,
	input  mmf_pkg::pixel_in_t                pix,
	output logic                              res_valid,
	input  logic                              res_ready,
	output mmf_pkg::pixel_out_t               res,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [mmf_pkg::ADDR_BITS-1:0]     paddr,
	input  logic [mmf_pkg::DATA_BITS-1:0]     pwdata,
	output logic [mmf_pkg::DATA_BITS-1:0]     prdata,
	output logic                              pready
);
	import mmf_pkg::*;

	logic [POS_BITS-1:0]  row_q;
	logic [POS_BITS-1:0]  pos_q;
	logic [FILL_BITS-1:0] fill_q;

	logic                 full_load;
	logic [FILL_BITS-1:0] slot;
	logic [FILL_BITS-1:0] need;
	logic [FILL_BITS-1:0] fill_inc;
	logic                 done;
	logic [POS_BITS-1:0]  pos_inc;
	logic [POS_BITS-1:0]  pos_next;
	logic                 acc;
	logic                 shift;
	rgb_t                 pix_s;
	rgb_t [WIN-1:0]       cur;

	logic v1_s1, v2_s2, v3_s3, v4_s4, out_q;
	logic rdy1, rdy2, rdy3, rdy4, rdy_o;
	stage_en_t en;

	sample_t [WIN-1:0] win_r;
	sample_t [WIN-1:0] win_g;
	sample_t [WIN-1:0] win_b;
	out_sample_t       res_r;
	out_sample_t       res_g;
	out_sample_t       res_b;

	logic reg_sel;

	// register port
	assign pready  = 1'b1;
	assign reg_sel = (paddr[ADDR_BITS-1] == REG_ROW_POSITIONS);
	assign prdata  = reg_sel ? DATA_BITS'(row_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= ROW_POS_RESET;
		end else if (psel && penable && pwrite && pready && reg_sel) begin
			row_q <= pwdata[POS_BITS-1:0];
		end
	end

	// fill and position control
	assign full_load = (pos_q == '0);
	assign slot      = full_load ? fill_q : FIRST_COL_SLOT + FILL_BITS'(fill_q * 4'd3);
	assign need      = full_load ? FULL_LOAD : COL_LOAD;
	assign fill_inc  = fill_q + 4'd1;
	assign done      = (fill_inc == need);
	assign pos_inc   = pos_q + 16'd1;
	assign pos_next  = (pos_inc == row_q) ? '0 : pos_inc;

	assign acc   = pix_valid && pix_ready;
	assign shift = acc && done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			fill_q <= '0;
		end else if (acc) begin
			fill_q <= done ? '0 : fill_inc;
			if (done) begin
				pos_q <= pos_next;
			end
		end
	end

	assign pix_s.r = sample_t'(pix.red_in);
	assign pix_s.g = sample_t'(pix.green_in);
	assign pix_s.b = sample_t'(pix.blue_in);

	// row of window cells; the two left columns take their right neighbour on completion
	for (genvar j = 0; j < WIN; j++) begin : g_cell
		localparam int NB = ((j % 3) == 2) ? j : j + 1;
		localparam logic SHIFTS = ((j % 3) != 2);

		mmf_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.load   (acc && (slot == FILL_BITS'(j))),
			.shift  (shift && SHIFTS),
			.pix    (pix_s),
			.nbr    (cur[NB]),
			.cur    (cur[j])
		);

		assign win_r[j] = cur[j].r;
		assign win_g[j] = cur[j].g;
		assign win_b[j] = cur[j].b;
	end

	// stage handshake: each stage moves when its successor has room
	assign rdy_o = !out_q || res_ready;
	assign rdy4  = !v4_s4 || rdy_o;
	assign rdy3  = !v3_s3 || rdy4;
	assign rdy2  = !v2_s2 || rdy3;
	assign rdy1  = !v1_s1 || rdy2;

	assign pix_ready = rdy1 || !done;

	assign en.s1 = rdy1;
	assign en.s2 = rdy2;
	assign en.s3 = rdy3;
	assign en.s4 = rdy4;
	assign en.so = rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
			out_q <= 1'b0;
		end else begin
			if (en.s1) begin
				v1_s1 <= shift;
			end
			if (en.s2) begin
				v2_s2 <= v1_s1;
			end
			if (en.s3) begin
				v3_s3 <= v2_s2;
			end
			if (en.s4) begin
				v4_s4 <= v3_s3;
			end
			if (en.so) begin
				out_q <= v4_s4;
			end
		end
	end

	mmf_chan u_red (
		.clk (clk),
		.en  (en),
		.win (win_r),
		.res (res_r)
	);

	mmf_chan u_green (
		.clk (clk),
		.en  (en),
		.win (win_g),
		.res (res_g)
	);

	mmf_chan u_blue (
		.clk (clk),
		.en  (en),
		.win (win_b),
		.res (res_b)
	);

	assign res_valid     = out_q;
	assign res.red_out   = res_r;
	assign res.green_out = res_g;
	assign res.blue_out  = res_b;

endmodule
